FILE: sv/q2e_pkg.sv
// package for the quaternion to euler converter
// holds widths, angle constants and the cordic arctangent table; no dependencies
`default_nettype none
package q2e_pkg;
	localparam int IN_W = 16;
	localparam int IN_FRAC_BITS_DEF = 14;
	localparam int ANGLE_FRAC_BITS_DEF = 8;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int DEG_SHIFT = 24;
	// cordic datapath width: operands normalized to 2^39, growth below 2^42
	localparam int CW = 44;
	localparam int ZW = 36;
	localparam int ROLL_W = 18;
	localparam int PITCH_W = 17;
	localparam int YAW_W = 17;

	localparam logic signed [ZW-1:0] DEG90 = ZW'(64'sd90 <<< DEG_SHIFT);
	localparam logic signed [ZW-1:0] DEG180 = ZW'(64'sd180 <<< DEG_SHIFT);
	localparam logic signed [ZW-1:0] DEG360 = ZW'(64'sd360 <<< DEG_SHIFT);

	function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'd754974720; 5'd1: v = 32'd445687602;
			5'd2: v = 32'd235489088; 5'd3: v = 32'd119537938;
			5'd4: v = 32'd60000934; 5'd5: v = 32'd30029717;
			5'd6: v = 32'd15018523; 5'd7: v = 32'd7509720;
			5'd8: v = 32'd3754917; 5'd9: v = 32'd1877466;
			5'd10: v = 32'd938734; 5'd11: v = 32'd469367;
			5'd12: v = 32'd234684; 5'd13: v = 32'd117342;
			5'd14: v = 32'd58671; 5'd15: v = 32'd29335;
			5'd16: v = 32'd14668; 5'd17: v = 32'd7334;
			5'd18: v = 32'd3667; 5'd19: v = 32'd1833;
			5'd20: v = 32'd917; 5'd21: v = 32'd458;
			5'd22: v = 32'd229; 5'd23: v = 32'd115;
			5'd24: v = 32'd57; 5'd25: v = 32'd29;
			5'd26: v = 32'd14; 5'd27: v = 32'd7;
			5'd28: v = 32'd4; 5'd29: v = 32'd2;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return ZW'($signed({1'b0, v}));
	endfunction

	// pipeline control carried through a cordic unit
	typedef struct packed {
		logic       early;   // result fixed before the iterations
		logic       clamp90; // clamp final angle to +-90 instead of +-180
	} cord_ctl_t;
endpackage
`default_nettype wire

FILE: sv/q2e_cordic.sv
// pipelined vectoring cordic giving atan2 in degrees with 24 fraction bits
// depends on q2e_pkg; one register stage per normalize step, per iteration and for the final clamp
`default_nettype none
module q2e_cordic import q2e_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire                     clk,
	input  wire                     en,
	input  wire signed [CW-1:0]     num,
	input  wire signed [CW-1:0]     den,
	input  wire                     clamp90,
	output logic signed [ZW-1:0]    angle
);
	localparam int NS = 6; // normalize stages, shift 0..63 in binary steps
	localparam int TOT = NS + CORDIC_STEPS + 1;

	logic signed [CW-1:0] x_p [TOT];
	logic signed [CW-1:0] y_p [TOT];
	logic signed [ZW-1:0] z_p [TOT+1];
	cord_ctl_t            c_p [TOT];

	// entry: quadrant fold and special cases
	always_comb begin
		c_p[0].clamp90 = clamp90;
		c_p[0].early = 1'b0;
		x_p[0] = den;
		y_p[0] = num;
		z_p[0] = '0;
		if (den == 0 && num == 0) begin
			c_p[0].early = 1'b1;
		end else if (den < 0) begin
			z_p[0] = (num >= 0) ? DEG180 : -DEG180;
			x_p[0] = -den;
			y_p[0] = -num;
			if (num == 0) c_p[0].early = 1'b1;
		end else if (num == 0) begin
			c_p[0].early = 1'b1;
		end else if (den == 0) begin
			z_p[0] = (num > 0) ? DEG90 : -DEG90;
			c_p[0].early = 1'b1;
		end
	end

	genvar g;
	// normalize: keep doubling while below 2^39, 32,16,8,4,2,1 steps
	// a step of SH is taken when SH-1 doublings still leave the value below 2^39
	generate
		for (g = 0; g < NS; g++) begin : g_norm
			localparam int SH = 1 << (NS - 1 - g);
			localparam logic signed [CW-1:0] LIM = CW'(64'sd1 <<< (40 - SH));
			logic ok;
			assign ok = x_p[g] < LIM && y_p[g] < LIM && y_p[g] > -LIM;
			always_ff @(posedge clk) begin
				if (en) begin
					x_p[g+1] <= (ok && !c_p[g].early) ? (x_p[g] <<< SH) : x_p[g];
					y_p[g+1] <= (ok && !c_p[g].early) ? (y_p[g] <<< SH) : y_p[g];
					z_p[g+1] <= z_p[g];
					c_p[g+1] <= c_p[g];
				end
			end
		end
		for (g = 0; g < CORDIC_STEPS; g++) begin : g_it
			localparam int K = NS + g;
			localparam int SH = (g > CW - 1) ? CW - 1 : g;
			logic signed [CW-1:0] dx, dy;
			assign dx = y_p[K] >>> SH;
			assign dy = x_p[K] >>> SH;
			always_ff @(posedge clk) begin
				if (en) begin
					c_p[K+1] <= c_p[K];
					if (!c_p[K].early && y_p[K] > 0) begin
						x_p[K+1] <= x_p[K] + dx;
						y_p[K+1] <= y_p[K] - dy;
						z_p[K+1] <= z_p[K] + atan_deg(5'(g));
					end else if (!c_p[K].early && y_p[K] < 0) begin
						x_p[K+1] <= x_p[K] - dx;
						y_p[K+1] <= y_p[K] + dy;
						z_p[K+1] <= z_p[K] - atan_deg(5'(g));
					end else begin
						x_p[K+1] <= x_p[K];
						y_p[K+1] <= y_p[K];
						z_p[K+1] <= z_p[K];
					end
				end
			end
		end
	endgenerate

	// final clamp
	localparam int KF = NS + CORDIC_STEPS;
	logic signed [ZW-1:0] lim;
	logic signed [ZW-1:0] zc;
	always_comb begin
		lim = c_p[KF].clamp90 ? DEG90 : DEG180;
		zc = z_p[KF];
		if (zc > lim) zc = lim;
		if (zc < -lim) zc = -lim;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			z_p[TOT] <= zc;
		end
	end
	assign angle = z_p[TOT];
endmodule
`default_nettype wire

FILE: sv/q2e_isqrt.sv
// pipelined restoring integer square root of a 61 bit value, one result bit per stage
// depends on q2e_pkg; delay also carries the sine value and sign alongside
`default_nettype none
module q2e_isqrt import q2e_pkg::*; (
	input  wire                 clk,
	input  wire                 en,
	input  wire [60:0]          n_in,
	input  wire signed [CW-1:0] s_in,
	output logic [31:0]         root,
	output logic signed [CW-1:0] s_out
);
	localparam int NST = 31;
	logic [63:0]          n_p [NST+1];
	logic [63:0]          r_p [NST+1];
	logic signed [CW-1:0] s_p [NST+1];
	assign n_p[0] = 64'(n_in);
	assign r_p[0] = '0;
	assign s_p[0] = s_in;
	genvar g;
	generate
		for (g = 0; g < NST; g++) begin : g_st
			localparam logic [63:0] BIT = 64'd1 << (2 * (NST - 1 - g));
			always_ff @(posedge clk) begin
				if (en) begin
					s_p[g+1] <= s_p[g];
					if (n_p[g] >= r_p[g] + BIT) begin
						n_p[g+1] <= n_p[g] - (r_p[g] + BIT);
						r_p[g+1] <= (r_p[g] >> 1) + BIT;
					end else begin
						n_p[g+1] <= n_p[g];
						r_p[g+1] <= r_p[g] >> 1;
					end
				end
			end
		end
	endgenerate
	assign root = r_p[NST][31:0];
	assign s_out = s_p[NST];
endmodule
`default_nettype wire

FILE: sv/quaternion_to_euler_degrees.sv
// quaternion to euler angles in degrees, fixed point, deep pipeline
// a result passes stages s1 to s4, the isqrt stages, the cordic stages and the output register
// throughput: one transaction per cycle while the output is not stalled; s1 and s4 hold multiplies
// a stalled output freezes the whole pipeline; valid bits travel with the data
// reset clears the valid bits only; payload registers are not reset
// depends on q2e_pkg, q2e_cordic, q2e_isqrt
`default_nettype none
module quaternion_to_euler_degrees import q2e_pkg::*; #(
	parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire signed [IN_W-1:0]    quat_x,
	input  wire signed [IN_W-1:0]    quat_y,
	input  wire signed [IN_W-1:0]    quat_z,
	input  wire signed [IN_W-1:0]    quat_w,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic [ROLL_W-1:0]        roll_deg,
	output logic [PITCH_W-1:0]       pitch_deg,
	output logic [YAW_W-1:0]         yaw_deg
);
	// stage counts: s1 products, s2 sums, s3 pitch prep, s4 1 - s^2, 31 isqrt, cordic, s_out
	localparam int CLAT = CORDIC_STEPS + 7;
	localparam int ISQ = 31;
	localparam int LAT = 4 + ISQ + CLAT + 1;

	// whole pipe advances when the output slot is free or being taken
	logic en;
	logic [LAT-1:0] vld_q;
	assign en = !out_valid || out_ready;
	assign in_ready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_valid};
	end
	assign out_valid = vld_q[LAT-1];

	// s1: products
	logic signed [31:0] xx_s1, yy_s1, zz_s1, ww_s1, yz_s1, xw_s1, xy_s1, zw_s1, xz_s1, yw_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= quat_x * quat_x; yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z; ww_s1 <= quat_w * quat_w;
			yz_s1 <= quat_y * quat_z; xw_s1 <= quat_x * quat_w;
			xy_s1 <= quat_x * quat_y; zw_s1 <= quat_z * quat_w;
			xz_s1 <= quat_x * quat_z; yw_s1 <= quat_y * quat_w;
		end
	end

	// s2: atan2 operands and pitch argument
	logic signed [CW-1:0] rn_s2, rd_s2, yn_s2, yd_s2, arg_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			rn_s2 <= (CW'(yz_s1) + CW'(xw_s1)) <<< 1;
			rd_s2 <= -CW'(xx_s1) - CW'(yy_s1) + CW'(zz_s1) + CW'(ww_s1);
			yn_s2 <= (CW'(xy_s1) + CW'(zw_s1)) <<< 1;
			yd_s2 <= CW'(xx_s1) - CW'(yy_s1) - CW'(zz_s1) + CW'(ww_s1);
			arg_s2 <= (CW'(yw_s1) - CW'(xz_s1)) <<< 1;
		end
	end

	// s3: clamp, magnitude to 30 fraction bits
	// compared at 64 bits so that unity stays exact for any fraction width
	localparam logic signed [63:0] ONE = 64'sd1 <<< (2 * IN_FRAC_BITS);
	logic signed [63:0] argc;
	logic [63:0] mag;
	logic [63:0] s30;
	always_comb begin
		argc = 64'(arg_s2);
		if (argc > ONE) argc = ONE;
		if (argc < -ONE) argc = -ONE;
		mag = argc < 0 ? 64'(-argc) : 64'(argc);
		if (2 * IN_FRAC_BITS >= 30) s30 = mag >> (2 * IN_FRAC_BITS - 30);
		else s30 = mag << (30 - 2 * IN_FRAC_BITS);
	end
	logic [30:0] s30_s3;
	logic        neg_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			s30_s3 <= s30[30:0];
			neg_s3 <= argc < 0;
		end
	end

	// s4: 1 - s^2 and signed sine, registered ahead of the square root
	logic [61:0] sq;
	assign sq = 62'(s30_s3) * 62'(s30_s3);
	logic signed [CW-1:0] ssig;
	assign ssig = neg_s3 ? -CW'(s30_s3) : CW'(s30_s3);
	logic [60:0] rad_s4;
	logic signed [CW-1:0] ssig_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4 <= 61'((62'd1 << 60) - sq);
			ssig_s4 <= ssig;
		end
	end

	// pitch: isqrt then cordic
	logic [31:0] c30;
	logic signed [CW-1:0] sdel;
	q2e_isqrt u_isqrt (
		.clk(clk), .en(en), .n_in(rad_s4), .s_in(ssig_s4), .root(c30), .s_out(sdel)
	);
	logic signed [ZW-1:0] pitch_a;
	q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .en(en), .num(sdel), .den(CW'(c30)),
		.clamp90(1'b1), .angle(pitch_a)
	);

	// roll and yaw operands delayed to line up with the pitch cordic entry
	localparam int DLY = 2 + ISQ;
	logic signed [CW-1:0] rn_d [DLY], rd_d [DLY], yn_d [DLY], yd_d [DLY];
	always_ff @(posedge clk) begin
		if (en) begin
			rn_d[0] <= rn_s2; rd_d[0] <= rd_s2; yn_d[0] <= yn_s2; yd_d[0] <= yd_s2;
			for (int i = 1; i < DLY; i++) begin
				rn_d[i] <= rn_d[i-1]; rd_d[i] <= rd_d[i-1];
				yn_d[i] <= yn_d[i-1]; yd_d[i] <= yd_d[i-1];
			end
		end
	end
	logic signed [ZW-1:0] roll_a, yaw_a;
	q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .en(en), .num(rn_d[DLY-1]), .den(rd_d[DLY-1]),
		.clamp90(1'b0), .angle(roll_a)
	);
	q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
		.clk(clk), .en(en), .num(yn_d[DLY-1]), .den(yd_d[DLY-1]),
		.clamp90(1'b0), .angle(yaw_a)
	);

	// output wrap and rounding
	localparam int FS = DEG_SHIFT - ANGLE_FRAC_BITS;
	localparam logic [ZW-1:0] HALF_W = ZW'(64'd1 << (DEG_SHIFT - 1));
	localparam logic [ZW-1:0] FMASK = ZW'((64'd1 << DEG_SHIFT) - 1);
	localparam logic [ZW-1:0] HALF_F = ZW'(64'd1 << (FS - 1));

	function automatic logic [ZW-1:0] rnd_whole(input logic [ZW-1:0] v);
		logic [ZW-1:0] n;
		n = v >> DEG_SHIFT;
		if ((v & FMASK) > HALF_W) n = n + 1'b1;
		return n << ANGLE_FRAC_BITS;
	endfunction
	function automatic logic [ZW-1:0] rnd_fine(input logic [ZW-1:0] v);
		return (v + HALF_F) >> FS;
	endfunction

	logic [ZW-1:0] r_o, p_o, y_o;
	always_comb begin
		r_o = roll_a < 0 ? rnd_whole(ZW'(DEG360 - roll_a)) : rnd_fine(ZW'(roll_a));
		p_o = pitch_a > 0 ? rnd_whole(ZW'(DEG360 + pitch_a)) : rnd_fine(ZW'(-pitch_a));
		if (yaw_a < 0) y_o = rnd_whole(ZW'(-yaw_a));
		else if (yaw_a > 0) y_o = rnd_whole(ZW'(DEG360 - yaw_a));
		else y_o = '0;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			roll_deg <= r_o[ROLL_W-1:0];
			pitch_deg <= p_o[PITCH_W-1:0];
			yaw_deg <= y_o[YAW_W-1:0];
		end
	end
endmodule
`default_nettype wire
